FILE: src/rcfd_pkg.sv
// Package for the remote-control receiver frame decoder.
// Holds shared constants, the status codes and the decoded frame struct.
// No dependencies.
package rcfd_pkg;

  localparam int MIN_FRAME_BYTES = 18;
  localparam int COUNTER_BITS    = 8;

  localparam int STORED_BYTES  = 16;
  localparam int NUM_COUNTERS  = 18;
  localparam int CNT_IDX_W     = $clog2(NUM_COUNTERS);
  localparam int BYTE_CNT_W    = 5;
  localparam int NUM_KEYS      = 16;
  localparam int KEY_NO_COUNT_A = 4;
  localparam int KEY_NO_COUNT_B = 5;
  localparam int LEFT_BTN_CNT  = 16;
  localparam int RIGHT_BTN_CNT = 17;

  localparam int STICK_W   = 11;
  localparam int DB_W      = 10;
  localparam int MOTION_W  = 16;
  localparam int CVAL_W    = 8;

  localparam logic [DB_W-1:0]       DEADBAND_RESET = 10'd8;
  localparam logic [3:0]            SAFE_SWITCHES  = 4'hD;
  localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX   = 5'd31;

  localparam int PADDR_W  = 3;
  localparam logic [0:0] REG_STICK_DEADBAND = 1'b0;

  typedef enum logic [1:0] {
    ST_DECODED = 2'd0,
    ST_SHORT   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_COUNTER = 2'd3
  } status_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0]          keys;
    logic [1:0]                   buttons;
    logic [2:0][MOTION_W-1:0]     motion;
    logic [3:0]                   switches;
    logic [3:0][STICK_W-1:0]      sticks;
  } frame_t;

endpackage

FILE: src/rcfd_unpack.sv
// Frame field unpacker: sticks with centering and deadband, switches, mouse and keys.
// Purely combinational. Depends on rcfd_pkg.
module rcfd_unpack (
  input  logic [rcfd_pkg::STORED_BYTES-1:0][7:0] bytes,
  input  logic [rcfd_pkg::DB_W-1:0]              deadband,
  output rcfd_pkg::frame_t                       frame
);

  function automatic logic [rcfd_pkg::STICK_W-1:0] centre(
    input logic [rcfd_pkg::STICK_W-1:0] raw,
    input logic [rcfd_pkg::DB_W-1:0]    db
  );
    logic [rcfd_pkg::STICK_W-1:0] v;
    logic signed [rcfd_pkg::STICK_W:0] v_ext;
    logic signed [rcfd_pkg::STICK_W:0] db_ext;
    // raw - 1024 is raw with the top bit inverted
    v      = {~raw[rcfd_pkg::STICK_W-1], raw[rcfd_pkg::STICK_W-2:0]};
    v_ext  = signed'({v[rcfd_pkg::STICK_W-1], v});
    db_ext = signed'({2'b00, db});
    if (v_ext <= db_ext && v_ext >= -db_ext) begin
      v = '0;
    end
    return v;
  endfunction

  always_comb begin
    frame.sticks[0] = centre({bytes[1][2:0], bytes[0]}, deadband);
    frame.sticks[1] = centre({bytes[2][5:0], bytes[1][7:3]}, deadband);
    frame.sticks[2] = centre({bytes[4][0], bytes[3], bytes[2][7:6]}, deadband);
    frame.sticks[3] = centre({bytes[5][3:0], bytes[4][7:1]}, deadband);
    frame.switches  = bytes[5][7:4];
    frame.motion[0] = {bytes[7], bytes[6]};
    frame.motion[1] = {bytes[9], bytes[8]};
    frame.motion[2] = {bytes[11], bytes[10]};
    frame.buttons   = {|bytes[13], |bytes[12]};
    frame.keys      = {bytes[15], bytes[14]};
  end

endmodule

FILE: src/rc_receiver_frame_decoder_unit.sv
// Remote-control receiver frame decoder, top level.
// Input register, byte store, held values, edge counters, result register, APB port.
// Depends on rcfd_pkg and rcfd_unpack.
//
// Frame bytes and counter accesses enter on the s_ stream, one item per clock at
// full rate while m_ is not stalled. Each item passes through an input register
// and is resolved into the result register, whose output drives m_; a stalled m_
// holds the result there. The input register can take one more item while a
// result waits. Only a last frame byte or a counter access yields a result.
// Frames shorter than the minimum report zero sticks and safe switches; frames
// whose first six bytes are zero report the held values. stick_deadband sits at
// address 0; the user must write it only while the block is idle, which the
// block itself does not enforce.
module rc_receiver_frame_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] data_byte, [12:8] counter_index, [13] clear_after_read
  input  logic [15:0]                     s_tdata,
  // [0] req_type
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
  // [47:44] switches, [63:48] mouse_dx, [79:64] mouse_dy, [95:80] mouse_dz,
  // [97:96] mouse_buttons, [113:98] key_bits, [121:114] counter_value
  output logic [127:0]                    m_tdata,
  // [1:0] frame_status
  output logic [1:0]                      m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcfd_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CB = rcfd_pkg::COUNTER_BITS;

  // configuration
  logic [rcfd_pkg::DB_W-1:0] stick_deadband;
  logic                      cfg_sel0;

  assign pready   = 1'b1;
  assign cfg_sel0 = (paddr[2] == rcfd_pkg::REG_STICK_DEADBAND);
  assign prdata   = cfg_sel0 ? 32'(stick_deadband) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_deadband <= rcfd_pkg::DEADBAND_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel0) begin
      stick_deadband <= pwdata[rcfd_pkg::DB_W-1:0];
    end
  end

  // input register
  logic                           s1_valid;
  logic                           s1_req;
  logic [7:0]                     s1_data;
  logic                           s1_last;
  logic [rcfd_pkg::CNT_IDX_W-1:0] s1_idx;
  logic                           s1_clr;
  logic                           advance;
  logic                           proc;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign proc     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_req  <= s_tuser;
      s1_data <= s_tdata[7:0];
      s1_last <= s_tlast;
      s1_idx  <= s_tdata[12:8];
      s1_clr  <= s_tdata[13];
    end
  end

  // state
  logic [rcfd_pkg::STORED_BYTES-1:0][7:0] frame_bytes;
  logic [rcfd_pkg::BYTE_CNT_W-1:0]        byte_count;
  rcfd_pkg::frame_t                       held;
  logic [CB-1:0]                          counters [rcfd_pkg::NUM_COUNTERS];

  logic [rcfd_pkg::STORED_BYTES-1:0][7:0] eff_bytes;
  logic [rcfd_pkg::BYTE_CNT_W-1:0]        count_next;
  rcfd_pkg::frame_t                       decoded;
  rcfd_pkg::frame_t                       held_next;
  logic                                   is_short;
  logic                                   is_zero;
  logic                                   do_decode;
  logic                                   idx_ok;
  logic [CB-1:0]                          cnt_read;
  rcfd_pkg::status_t                      status;
  logic                                   has_result;
  logic [rcfd_pkg::NUM_COUNTERS-1:0]      now_bits;
  logic [rcfd_pkg::NUM_COUNTERS-1:0]      old_bits;

  // the byte in flight is visible to the decode of its own frame
  always_comb begin
    for (int i = 0; i < rcfd_pkg::STORED_BYTES; i++) begin
      eff_bytes[i] = (byte_count == rcfd_pkg::BYTE_CNT_W'(i)) ? s1_data : frame_bytes[i];
    end
  end

  rcfd_unpack u_unpack (
    .bytes    (eff_bytes),
    .deadband (stick_deadband),
    .frame    (decoded)
  );

  assign count_next = (byte_count < rcfd_pkg::BYTE_CNT_MAX) ?
                      byte_count + rcfd_pkg::BYTE_CNT_W'(1) : byte_count;
  assign is_short   = count_next < rcfd_pkg::BYTE_CNT_W'(rcfd_pkg::MIN_FRAME_BYTES);
  assign is_zero    = ~|{eff_bytes[5], eff_bytes[4], eff_bytes[3],
                         eff_bytes[2], eff_bytes[1], eff_bytes[0]};
  assign do_decode  = proc && !s1_req && s1_last && !is_short && !is_zero;
  assign idx_ok     = s1_idx < rcfd_pkg::CNT_IDX_W'(rcfd_pkg::NUM_COUNTERS);
  assign cnt_read   = idx_ok ? counters[s1_idx] : '0;
  assign has_result = s1_req || s1_last;

  assign now_bits = {decoded.buttons, decoded.keys};
  assign old_bits = {held.buttons, held.keys};

  always_comb begin
    held_next = held;
    status    = rcfd_pkg::ST_COUNTER;
    if (s1_req) begin
      status = rcfd_pkg::ST_COUNTER;
    end else if (is_short) begin
      held_next.sticks   = '0;
      held_next.switches = rcfd_pkg::SAFE_SWITCHES;
      status             = rcfd_pkg::ST_SHORT;
    end else if (is_zero) begin
      status = rcfd_pkg::ST_ZERO;
    end else begin
      held_next = decoded;
      status    = rcfd_pkg::ST_DECODED;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !s1_req && byte_count < rcfd_pkg::BYTE_CNT_W'(rcfd_pkg::STORED_BYTES)) begin
      frame_bytes[byte_count[$clog2(rcfd_pkg::STORED_BYTES)-1:0]] <= s1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      held       <= '0;
      for (int i = 0; i < rcfd_pkg::NUM_COUNTERS; i++) begin
        counters[i] <= '0;
      end
    end else if (proc) begin
      if (!s1_req) begin
        byte_count <= s1_last ? '0 : count_next;
      end
      if (!s1_req && s1_last) begin
        held <= held_next;
      end
      if (s1_req && s1_clr && idx_ok) begin
        counters[s1_idx] <= '0;
      end
      if (do_decode) begin
        for (int i = 0; i < rcfd_pkg::NUM_COUNTERS; i++) begin
          if (i != rcfd_pkg::KEY_NO_COUNT_A && i != rcfd_pkg::KEY_NO_COUNT_B &&
              now_bits[i] && !old_bits[i]) begin
            counters[i] <= counters[i] + CB'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= proc && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && has_result) begin
      m_tdata[10:0]    <= held_next.sticks[0];
      m_tdata[21:11]   <= held_next.sticks[1];
      m_tdata[32:22]   <= held_next.sticks[2];
      m_tdata[43:33]   <= held_next.sticks[3];
      m_tdata[47:44]   <= held_next.switches;
      m_tdata[63:48]   <= held_next.motion[0];
      m_tdata[79:64]   <= held_next.motion[1];
      m_tdata[95:80]   <= held_next.motion[2];
      m_tdata[97:96]   <= held_next.buttons;
      m_tdata[113:98]  <= held_next.keys;
      m_tdata[121:114] <= s1_req ? rcfd_pkg::CVAL_W'(cnt_read) : '0;
      m_tdata[127:122] <= '0;
      m_tuser          <= status;
    end
  end

  a_frame_end_clears_count: assert property (@(posedge clk) disable iff (rst)
    proc && !s1_req && s1_last |=> byte_count == '0)
    else $error("byte count not cleared at frame end");

  a_short_safe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rcfd_pkg::ST_SHORT |->
      m_tdata[47:44] == rcfd_pkg::SAFE_SWITCHES && m_tdata[43:0] == '0)
    else $error("short frame result not in safe state");

  a_cval_only_on_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != rcfd_pkg::ST_COUNTER |-> m_tdata[121:114] == '0)
    else $error("counter value on frame result");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_held_stable_on_read: assert property (@(posedge clk) disable iff (rst)
    proc && s1_req |=> held == $past(held) && byte_count == $past(byte_count))
    else $error("counter access disturbed frame state");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for rc_receiver_frame_decoder_unit.
// Streams frame bytes and counter reads against an in-bench decoder model and
// sweeps the stick deadband over APB. Depends on rcfd_pkg and the RTL.
module tb;
  import rcfd_pkg::*;

  localparam logic REQ_FRAME   = 1'b0;
  localparam logic REQ_COUNTER = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_DEADBAND = PADDR_W'(4 * REG_STICK_DEADBAND);
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_FRAME   = 40;
  localparam int MAX_PRINTS  = 50;

  typedef enum int {FK_RANDOM, FK_STICKS, FK_ZERO} frame_kind_t;

  typedef struct packed {
    logic [CVAL_W-1:0] cval;
    status_t           status;
    frame_t            fr;
  } report_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata  = '0;
  logic               s_tuser  = 1'b0;
  logic               s_tlast  = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [127:0]       m_tdata;
  logic [1:0]         m_tuser;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  rc_receiver_frame_decoder_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder model state
  logic [7:0]              frame_store [STORED_BYTES];
  logic [BYTE_CNT_W-1:0]   bytes_seen;
  frame_t                  held;
  logic [COUNTER_BITS-1:0] edge_cnt [NUM_COUNTERS];
  logic [DB_W-1:0]         deadband;

  report_t reports_due[$];
  int      errors      = 0;
  int      items_sent  = 0;
  int      burst_left  = 0;
  int      n_decoded   = 0;
  int      n_short     = 0;
  int      n_zero      = 0;
  int      n_counter   = 0;
  int      n_settings  = 1;
  bit      hold_on     = 1'b0;
  int      hold_count  = 0;
  int      rx_mode     = 0;
  int      rx_left     = 0;
  int      quiet       = 0;

  function automatic logic [STICK_W-1:0] centre_stick(input logic [STICK_W-1:0] raw);
    int v;
    int db;
    v  = int'(raw) - 1024;
    db = int'(deadband);
    if (v <= db && v >= -db) v = 0;
    return STICK_W'(v);
  endfunction

  function automatic logic [STICK_W-1:0] pick_raw();
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 2047;
      2: v = 1024;
      5: v = int'($urandom_range(0, 2047));
      default: begin
        v = int'($urandom_range(0, 2 * int'(deadband) + 4));
        v = v + 1022 - int'(deadband);
      end
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return STICK_W'(v);
  endfunction

  task automatic predict_report(input logic req, input logic [7:0] data, input logic last,
                                input logic [4:0] idx, input logic clr);
    report_t     r;
    int          n;
    logic [47:0] hdr;
    logic [15:0] keys;
    logic [1:0]  btn;
    r = '0;
    if (req == REQ_COUNTER) begin
      if (idx < NUM_COUNTERS) begin
        r.cval = edge_cnt[idx];
        if (clr) edge_cnt[idx] = '0;
      end
      r.status = ST_COUNTER;
      r.fr     = held;
      reports_due.push_back(r);
      n_counter++;
    end else begin
      if (bytes_seen < STORED_BYTES) frame_store[bytes_seen] = data;
      if (bytes_seen < BYTE_CNT_MAX) bytes_seen++;
      if (last) begin
        n = int'(bytes_seen);
        bytes_seen = '0;
        if (n < MIN_FRAME_BYTES) begin
          held.sticks   = '0;
          held.switches = SAFE_SWITCHES;
          r.status      = ST_SHORT;
          n_short++;
        end else if ((frame_store[0] | frame_store[1] | frame_store[2] | frame_store[3] |
                      frame_store[4] | frame_store[5]) == 8'd0) begin
          r.status = ST_ZERO;
          n_zero++;
        end else begin
          for (int i = 0; i < 6; i++) hdr[8*i +: 8] = frame_store[i];
          held.sticks[0] = centre_stick(hdr[10:0]);
          held.sticks[1] = centre_stick(hdr[21:11]);
          held.sticks[2] = centre_stick(hdr[32:22]);
          held.sticks[3] = centre_stick(hdr[43:33]);
          held.switches  = hdr[47:44];
          held.motion[0] = {frame_store[7], frame_store[6]};
          held.motion[1] = {frame_store[9], frame_store[8]};
          held.motion[2] = {frame_store[11], frame_store[10]};
          btn  = {frame_store[13] != 8'd0, frame_store[12] != 8'd0};
          keys = {frame_store[15], frame_store[14]};
          for (int i = 0; i < NUM_KEYS; i++)
            if (i != KEY_NO_COUNT_A && i != KEY_NO_COUNT_B && keys[i] && !held.keys[i])
              edge_cnt[i]++;
          if (btn[0] && !held.buttons[0]) edge_cnt[LEFT_BTN_CNT]++;
          if (btn[1] && !held.buttons[1]) edge_cnt[RIGHT_BTN_CNT]++;
          held.buttons = btn;
          held.keys    = keys;
          r.status     = ST_DECODED;
          n_decoded++;
        end
        r.fr = held;
        reports_due.push_back(r);
      end
    end
  endtask

  task automatic send_item(input logic req, input logic [7:0] data, input logic last,
                           input logic [4:0] idx, input logic clr);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(40, 150);
      end else begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tlast  <= last;
    s_tdata  <= {2'b00, clr, idx, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    predict_report(req, data, last, idx, clr);
  endtask

  task automatic send_counter_read();
    logic [4:0] idx;
    idx = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
    send_item(REQ_COUNTER, 8'($urandom), 1'($urandom_range(0, 1)), idx,
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input int len, input frame_kind_t kind);
    logic [7:0]  b [MAX_FRAME];
    logic [47:0] hdr;
    for (int i = 0; i < MAX_FRAME; i++) b[i] = 8'($urandom);
    if (kind == FK_STICKS) begin
      hdr = {4'($urandom), pick_raw(), pick_raw(), pick_raw(), pick_raw()};
      for (int i = 0; i < 6; i++) b[i] = hdr[8*i +: 8];
    end else if (kind == FK_ZERO) begin
      for (int i = 0; i < 6; i++) b[i] = 8'h00;
    end
    if ($urandom_range(0, 1) == 0) b[12] = 8'h00;
    if ($urandom_range(0, 1) == 0) b[13] = 8'h00;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 39) == 0) send_counter_read();
      send_item(REQ_FRAME, b[i], i == len - 1, 5'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_fixed_frame(input logic [7:0] hdr_fill, input logic [7:0] body_fill,
                                  input int len);
    for (int i = 0; i < len; i++)
      send_item(REQ_FRAME, (i < 6) ? hdr_fill : body_fill, i == len - 1, 5'd0, 1'b0);
  endtask

  task automatic run_random(input int n_items);
    int          start;
    int          r;
    int          len;
    frame_kind_t kind;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                  5'($urandom), 1'($urandom_range(0, 1)));
      end else if (r < 18) begin
        send_counter_read();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65)      len = MIN_FRAME_BYTES;
        else if (r < 75) len = $urandom_range(16, MIN_FRAME_BYTES - 1);
        else if (r < 82) len = $urandom_range(1, 15);
        else if (r < 94) len = $urandom_range(MIN_FRAME_BYTES + 1, 31);
        else             len = $urandom_range(32, MAX_FRAME);
        r = $urandom_range(0, 99);
        if (r < 15)      kind = FK_ZERO;
        else if (r < 55) kind = FK_STICKS;
        else             kind = FK_RANDOM;
        send_frame(len, kind);
      end
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [DB_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DEADBAND;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    deadband = val;
    n_settings++;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch %s: got %h want %h (item %0d)", field, got, want, items_sent);
    errors++;
  endtask

  task automatic test_reset_state();
    send_item(REQ_COUNTER, 8'h00, 1'b0, 5'd0, 1'b0);
  endtask

  task automatic test_short_frame();
    send_item(REQ_FRAME, 8'hFF, 1'b1, 5'd31, 1'b1);
  endtask

  task automatic test_zero_header();
    send_fixed_frame(8'h00, 8'hFF, MIN_FRAME_BYTES);
  endtask

  task automatic test_decode_extremes();
    send_fixed_frame(8'hFF, 8'hFF, MIN_FRAME_BYTES);
  endtask

  task automatic test_counter_access();
    send_item(REQ_COUNTER, 8'hFF, 1'b1, 5'd0, 1'b1);
    send_item(REQ_COUNTER, 8'h00, 1'b0, 5'(KEY_NO_COUNT_A), 1'b1);
    send_item(REQ_COUNTER, 8'h00, 1'b0, 5'(LEFT_BTN_CNT), 1'b1);
    send_item(REQ_COUNTER, 8'h00, 1'b0, 5'(RIGHT_BTN_CNT), 1'b0);
    send_item(REQ_COUNTER, 8'h00, 1'b0, 5'd31, 1'b1);
    send_item(REQ_COUNTER, 8'h00, 1'b0, 5'd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_deadband_settings();
    run_random(300);
    wait_idle();
    write_deadband('0);
    run_random(300);
    wait_idle();
    write_deadband({DB_W{1'b1}});
    run_random(250);
    wait_idle();
    write_deadband(DB_W'($urandom_range(2, 1022)));
    run_random(300);
    wait_idle();
    write_deadband(DB_W'(1));
    run_random(250);
    wait_idle();
    write_deadband(DEADBAND_RESET);
  endtask

  task automatic test_receiver_backpressure();
    hold_on = 1'b1;
    run_random(300);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_on) begin
      m_tready <= 1'b0;
      hold_count = hold_count + 1;
      if (hold_count >= LONG_HOLD) begin
        hold_on    = 1'b0;
        hold_count = 0;
      end
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= (rx_left % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    report_t want;
    frame_t  got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(frame_t)-1:0];
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = reports_due.pop_front();
        for (int k = 0; k < 4; k++)
          if (got.sticks[k] !== want.fr.sticks[k])
            report_mismatch($sformatf("stick_%0d", k), 32'(got.sticks[k]),
                            32'(want.fr.sticks[k]));
        if (got.switches !== want.fr.switches)
          report_mismatch("switches", 32'(got.switches), 32'(want.fr.switches));
        for (int k = 0; k < 3; k++)
          if (got.motion[k] !== want.fr.motion[k])
            report_mismatch($sformatf("mouse_d%s", (k == 0) ? "x" : (k == 1) ? "y" : "z"),
                            32'(got.motion[k]), 32'(want.fr.motion[k]));
        if (got.buttons !== want.fr.buttons)
          report_mismatch("mouse_buttons", 32'(got.buttons), 32'(want.fr.buttons));
        if (got.keys !== want.fr.keys)
          report_mismatch("key_bits", 32'(got.keys), 32'(want.fr.keys));
        if (m_tuser !== want.status)
          report_mismatch("frame_status", 32'(m_tuser), 32'(want.status));
        if (m_tdata[121:114] !== want.cval)
          report_mismatch("counter_value", 32'(m_tdata[121:114]), 32'(want.cval));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORED_BYTES; i++) frame_store[i] = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) edge_cnt[i] = '0;
    bytes_seen = '0;
    held       = '0;
    deadband   = DEADBAND_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_short_frame();
    test_zero_header();
    test_decode_extremes();
    test_counter_access();
    test_deadband_settings();
    test_receiver_backpressure();
    wait_idle();

    $display("covered %0d items: %0d decoded, %0d short, %0d zero-header frames, %0d counter reads",
             items_sent, n_decoded, n_short, n_zero, n_counter);
    $display("deadband settings used: %0d, field mismatches: %0d", n_settings, errors);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
